FILE: design/pic_pkg.sv
// Package for the platform interrupt controller: opcodes, register map
// constants and default parameter values. No dependencies.
package pic_pkg;
  localparam int NumSourcesDef  = 32;
  localparam int NumContextsDef = 2;
  localparam int PrioBitsDef    = 3;

  localparam logic [1:0] OpRead   = 2'd0;
  localparam logic [1:0] OpWrite  = 2'd1;
  localparam logic [1:0] OpSample = 2'd2;

  localparam logic [23:0] PendBase  = 24'h001000;
  localparam logic [23:0] EnBase    = 24'h002000;
  localparam logic [23:0] CtxBase   = 24'h200000;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic start;      // load request, begin work
    logic scan_en;    // advance the source scan
    logic scan_clr;   // restart scan index
    logic ctx_sel;    // 0: scan for request context, 1: irq pass
    logic commit;     // apply request effects
    logic out_load;   // capture result
  } pic_cmd_t;

  typedef struct packed {
    logic scan_last;
  } pic_sts_t;
endpackage

FILE: design/pic_if.sv
// Valid/ready channel carrying one payload.
// Depends on nothing; payload type is a parameter.
interface pic_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/platform_interrupt_controller.sv
// Platform interrupt controller top level: sequencer plus datapath.
// Each request is handled in turn by two serial passes over the sources (claim,
// irq); a new request is taken only after the last one's result is loaded, and
// a stalled result holds the next request.
// Reset (rst, synchronous) clears priorities, enables, thresholds, pending and
// in-service bits; no clearing pass is needed.
module platform_interrupt_controller #(
  parameter int NUM_SOURCES  = pic_pkg::NumSourcesDef,
  parameter int NUM_CONTEXTS = pic_pkg::NumContextsDef,
  parameter int PRIO_BITS    = pic_pkg::PrioBitsDef
) (
  input logic clk,
  input logic rst,
  pic_if.sink   req,
  pic_if.source rsp
);
  pic_pkg::pic_cmd_t cmd;
  pic_pkg::pic_sts_t sts;

  // Sequencer: accept, scan for the claim, commit, scan for irq, deliver.
  pic_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .sts, .cmd
  );

  // Datapath holds all register state and the result register.
  pic_dp #(.NUM_SOURCES(NUM_SOURCES), .NUM_CONTEXTS(NUM_CONTEXTS),
           .PRIO_BITS(PRIO_BITS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .opcode(req.data.opcode), .address(req.data.address),
    .write_data(req.data.write_data), .source_levels(req.data.source_levels),
    .read_data(rsp.data.read_data), .context_irq(rsp.data.context_irq),
    .access_error(rsp.data.access_error)
  );
endmodule

FILE: design/pic_ctrl.sv
// Sequencer for the interrupt controller: one request at a time.
// Depends on pic_pkg.
module pic_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pic_pkg::pic_sts_t sts,
  output pic_pkg::pic_cmd_t cmd
);
  typedef enum logic [4:0] {
    SIdle = 5'b00001, SScan = 5'b00010, SCommit = 5'b00100,
    SIrq = 5'b01000, SOut = 5'b10000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= SIdle;
    else state <= state_next;
  end

  // Output register frees the front once the result is captured.
  logic hold;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  assign hold = out_valid && !out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      SIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = SScan;
        end
      end
      SScan: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) state_next = SCommit;
      end
      SCommit: begin
        cmd.commit = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = SIrq;
      end
      SIrq: begin
        cmd.ctx_sel = 1'b1;
        cmd.scan_en = 1'b1;
        if (sts.scan_last) state_next = SOut;
      end
      SOut: begin
        if (!hold) begin
          cmd.out_load = 1'b1;
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end
endmodule

FILE: design/pic_dp.sv
// Datapath: register file, level gateway and serial claim scan.
// Depends on pic_pkg.
module pic_dp #(
  parameter int NUM_SOURCES  = pic_pkg::NumSourcesDef,
  parameter int NUM_CONTEXTS = pic_pkg::NumContextsDef,
  parameter int PRIO_BITS    = pic_pkg::PrioBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  pic_pkg::pic_cmd_t cmd,
  output pic_pkg::pic_sts_t sts,
  input  logic [1:0]        opcode,
  input  logic [23:0]       address,
  input  logic [31:0]       write_data,
  input  logic [31:0]       source_levels,
  output logic [31:0]       read_data,
  output logic [1:0]        context_irq,
  output logic              access_error
);
  localparam int SW = $clog2(NUM_SOURCES);
  localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int NumWords = (NUM_SOURCES + 31) / 32;
  localparam int IrqCtx = (NUM_CONTEXTS < 2) ? NUM_CONTEXTS : 2;
  localparam logic [63:0] SrcMask =
    ((NUM_SOURCES >= 64) ? {64{1'b1}} : ((64'd1 << NUM_SOURCES) - 64'd1)) & ~64'd1;

  logic [PRIO_BITS-1:0]   prio [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] pend, insvc;
  logic [NUM_SOURCES-1:0] en [NUM_CONTEXTS];
  logic [PRIO_BITS-1:0]   thr [NUM_CONTEXTS];

  // Request registers.
  logic [1:0]  op_q;
  logic [23:0] a_q;
  logic [31:0] wd_q;

  // Decode of the held request.
  logic        is_acc, dec_err, dec_prio, dec_pend, dec_en, dec_thr, dec_claim;
  logic [21:0] n_idx;
  logic [23:0] en_off, ctx_off;
  logic [16:0] en_cx;
  logic [4:0]  en_w;
  logic [11:0] ctx_cx;
  logic [11:0] ctx_r;
  logic [9:0]  pend_w;
  logic [CW-1:0] req_cx;
  logic [SW-1:0] n_sel;
  logic          w_sel;

  always_comb begin
    is_acc = (op_q == pic_pkg::OpRead) || (op_q == pic_pkg::OpWrite);
    n_idx = a_q[23:2];
    en_off = a_q - pic_pkg::EnBase;
    ctx_off = a_q - pic_pkg::CtxBase;
    en_cx = en_off[23:7];
    en_w = en_off[6:2];
    ctx_cx = ctx_off[23:12];
    ctx_r = ctx_off[11:0];
    pend_w = a_q[11:2];
    dec_prio = 1'b0; dec_pend = 1'b0; dec_en = 1'b0; dec_thr = 1'b0;
    dec_claim = 1'b0; dec_err = 1'b0;
    req_cx = '0;
    if (a_q[1:0] != 2'b00) dec_err = 1'b1;
    else if (a_q < pic_pkg::PendBase) begin
      if (n_idx >= 22'd1 && n_idx < 22'(NUM_SOURCES)) dec_prio = 1'b1;
      else dec_err = 1'b1;
    end else if (a_q < pic_pkg::EnBase) begin
      if (pend_w < 10'(NumWords) && op_q == pic_pkg::OpRead) dec_pend = 1'b1;
      else dec_err = 1'b1;
    end else if (a_q < pic_pkg::CtxBase) begin
      if (en_cx < 17'(NUM_CONTEXTS) && en_w < 5'(NumWords)) begin
        dec_en = 1'b1; req_cx = en_cx[CW-1:0];
      end else dec_err = 1'b1;
    end else begin
      if (ctx_cx >= 12'(NUM_CONTEXTS) || (ctx_r != 12'd0 && ctx_r != 12'd4))
        dec_err = 1'b1;
      else begin
        req_cx = ctx_cx[CW-1:0];
        if (ctx_r == 12'd0) dec_thr = 1'b1;
        else dec_claim = 1'b1;
      end
    end
    if (!is_acc) begin
      dec_err = 1'b0; dec_prio = 1'b0; dec_pend = 1'b0; dec_en = 1'b0;
      dec_thr = 1'b0; dec_claim = 1'b0;
    end
    n_sel = n_idx[SW-1:0];
    w_sel = (NumWords > 1) ? en_w[0] : 1'b0;
  end

  // Serial scan: one source per cycle, all lanes in parallel; irq flags captured in the irq pass.
  logic [SW-1:0]        idx;
  logic [PRIO_BITS-1:0] best_p [IrqCtx+1];
  logic [SW-1:0]        best_n;
  logic [IrqCtx-1:0]    irq_q;
  logic [PRIO_BITS-1:0] cur_p;

  assign sts.scan_last = (idx == SW'(NUM_SOURCES - 1));
  assign cur_p = prio[idx];

  // Lane 0..IrqCtx-1: irq contexts; lane IrqCtx: request context (claim).
  logic [CW-1:0] lane_cx [IrqCtx+1];
  always_comb begin
    for (int k = 0; k < IrqCtx; k++) lane_cx[k] = CW'(k);
    lane_cx[IrqCtx] = req_cx;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx <= '0;
      for (int k = 0; k <= IrqCtx; k++) best_p[k] <= '0;
      best_n <= '0;
    end else if (cmd.scan_en) begin
      idx <= (idx == SW'(NUM_SOURCES - 1)) ? idx : idx + SW'(1);
      for (int k = 0; k <= IrqCtx; k++) begin
        if (idx != '0 && pend[idx] && en[lane_cx[k]][idx] &&
            cur_p > thr[lane_cx[k]] && cur_p > best_p[k]) begin
          best_p[k] <= cur_p;
          if (k == IrqCtx) best_n <= idx;
        end
      end
    end
    if (cmd.scan_en && cmd.ctx_sel && sts.scan_last) begin
      for (int k = 0; k < IrqCtx; k++) irq_q[k] <= (best_p[k] != '0) ||
        (idx != '0 && pend[idx] && en[lane_cx[k]][idx] &&
         cur_p > thr[lane_cx[k]] && cur_p > best_p[k]);
    end
  end

  logic claim_hit;
  assign claim_hit = (best_p[IrqCtx] != '0);

  logic [63:0] lv64, pend64, en64;
  assign lv64 = 64'(source_levels);

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SOURCES; i++) prio[i] <= '0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en[c] <= '0; thr[c] <= '0;
      end
      pend <= '0; insvc <= '0;
    end else if (cmd.start && opcode == pic_pkg::OpSample) begin
      pend <= pend | (lv64[NUM_SOURCES-1:0] & SrcMask[NUM_SOURCES-1:0] & ~insvc);
    end else if (cmd.commit && op_q == pic_pkg::OpWrite) begin
      if (dec_prio) prio[n_sel] <= wd_q[PRIO_BITS-1:0];
      if (dec_thr) thr[req_cx] <= wd_q[PRIO_BITS-1:0];
      if (dec_en) begin
        for (int i = 0; i < NUM_SOURCES; i++)
          if ((i / 32) == int'(w_sel)) en[req_cx][i] <= wd_q[i % 32] & SrcMask[i];
      end
      if (dec_claim && wd_q >= 32'd1 && wd_q < 32'(NUM_SOURCES) &&
          en[req_cx][wd_q[SW-1:0]])
        insvc[wd_q[SW-1:0]] <= 1'b0;
    end else if (cmd.commit && op_q == pic_pkg::OpRead && dec_claim && claim_hit) begin
      pend[best_n] <= 1'b0;
      insvc[best_n] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q <= opcode; a_q <= address; wd_q <= write_data;
    end
  end

  // Read data captured at commit, before the state update.
  logic [31:0] rd_q;
  logic        err_q;
  always_comb begin
    pend64 = 64'(pend);
    en64 = 64'(en[req_cx]);
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      err_q <= dec_err;
      rd_q <= '0;
      if (op_q == pic_pkg::OpRead) begin
        if (dec_prio) rd_q <= 32'(prio[n_sel]);
        if (dec_pend) rd_q <= pend_w[0] ? pend64[63:32] : pend64[31:0];
        if (dec_en) rd_q <= w_sel ? en64[63:32] : en64[31:0];
        if (dec_thr) rd_q <= 32'(thr[req_cx]);
        if (dec_claim) rd_q <= claim_hit ? 32'(best_n) : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= rd_q;
      access_error <= err_q;
      context_irq <= 2'(irq_q);
    end
  end
endmodule

FILE: design/pic_checker.sv
// Port-level checks for the interrupt controller, bound to the top level.
// Depends on platform_interrupt_controller ports only.
module pic_checker (
  input logic clk, input logic rst,
  input logic in_valid, input logic in_ready,
  input logic out_valid, input logic out_ready,
  input logic [31:0] read_data
);
  // A valid result always carries known data.
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(read_data)) else $error("unknown result");
  // A taken request is never immediately followed by in_ready.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready too early");
  // Result holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
    else $error("result dropped");
endmodule

bind platform_interrupt_controller pic_checker u_chk (
  .clk, .rst, .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .read_data(rsp.data.read_data)
);
